// ===== rtl/sync_length_frame_deframer_core_defines.svh =====
// Assertion macros for the frame deframer core.
// No dependencies; included by the core, which checks its own logic.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SLDF_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define SLDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SLDF_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SLDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/sldf_pkg.sv =====
// Shared constants for the frame deframer: defaults, sync byte reset values, config indices,
// status codes, field widths. No dependencies.
package sldf_pkg;

    localparam int MAX_PAYLOAD_DEF  = 32;
    localparam int WINDOW_DEPTH_DEF = 64;

    localparam int LEN_BIAS   = 3;
    localparam int SYNC_BYTES = 2;

    localparam logic [7:0] START_FIRST_RST  = 8'd170;
    localparam logic [7:0] START_SECOND_RST = 8'd85;
    localparam logic [7:0] END_FIRST_RST    = 8'd13;
    localparam logic [7:0] END_SECOND_RST   = 8'd10;

    localparam logic [1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [1:0] CFG_START_SECOND = 2'd1;
    localparam logic [1:0] CFG_END_FIRST    = 2'd2;
    localparam logic [1:0] CFG_END_SECOND   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_NONE     = 2'd0;
    localparam t_status ST_FRAME    = 2'd1;
    localparam t_status ST_BAD      = 2'd2;
    localparam t_status ST_OVERFLOW = 2'd3;

    localparam int PLEN_W = 6;
    localparam int PIDX_W = 5;
    localparam int CNT_W  = 32;

endpackage

// ===== rtl/sldf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sldf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sync_length_frame_deframer_core.sv =====
// A result beat is registered once the scan decides: overflow in S_WR, a short window in S_SCAN,
// a partial frame in S_B or S_LEN, a bad length in S_LEN, bad end bytes in S_E1, an empty frame
// in S_H2 and payload beats in S_PAY; each dropped leading byte goes back through S_SCAN, S_A, S_B.
// The next beat is taken only back in S_IDLE, after the last result is registered; a stalled
// result holds the scan.
// Reset (synchronous, active low) zeroes fill and tallies, loads default sync bytes; no RAM clear.
`include "sync_length_frame_deframer_core_defines.svh"

module sync_length_frame_deframer_core #(
    parameter int MAX_PAYLOAD  = sldf_pkg::MAX_PAYLOAD_DEF,
    parameter int WINDOW_DEPTH = sldf_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [7:0]                 i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output sldf_pkg::t_status          o_status,
    output logic [7:0]                 o_source_id,
    output logic [7:0]                 o_dest_id,
    output logic [7:0]                 o_message_id,
    output logic [sldf_pkg::PLEN_W-1:0] o_payload_len,
    output logic [7:0]                 o_payload_byte,
    output logic [sldf_pkg::PIDX_W-1:0] o_payload_index,
    output logic                       o_last,
    output logic [sldf_pkg::CNT_W-1:0] o_frames_ok_total,
    output logic [sldf_pkg::CNT_W-1:0] o_format_errors_total,
    output logic [sldf_pkg::CNT_W-1:0] o_overflows_total
);

    import sldf_pkg::*;

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int OW = PW + 1;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [9:0] DECL_MIN = 10'(LEN_BIAS);
    localparam logic [9:0] DECL_MAX = 10'(MAX_PAYLOAD + LEN_BIAS);
    localparam logic [9:0] FRAME_EXTRA = 10'(SYNC_BYTES + 1 + SYNC_BYTES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WR   = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_A    = 4'd3;
    localparam logic [3:0] S_B    = 4'd4;
    localparam logic [3:0] S_LEN  = 4'd5;
    localparam logic [3:0] S_E0   = 4'd6;
    localparam logic [3:0] S_E1   = 4'd7;
    localparam logic [3:0] S_H0   = 4'd8;
    localparam logic [3:0] S_H1   = 4'd9;
    localparam logic [3:0] S_H2   = 4'd10;
    localparam logic [3:0] S_PAY  = 4'd11;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [OW-1:0] off);
        logic [PW+1:0] s;
        s = {2'b00, base} + {1'b0, off};
        if (s >= (PW+2)'(WINDOW_DEPTH)) begin
            s = s - (PW+2)'(WINDOW_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    logic [7:0] r_start_first, r_start_second, r_end_first, r_end_second;

    logic [3:0]       r_state, n_state;
    logic [PW-1:0]    r_head, n_head;
    logic [FW-1:0]    r_fill, n_fill;
    logic [7:0]       r_byte, n_byte;
    logic [7:0]       r_b0, n_b0;
    logic [7:0]       r_decl, n_decl;
    logic [7:0]       r_src, n_src;
    logic [7:0]       r_dst, n_dst;
    logic [7:0]       r_mid, n_mid;
    logic [7:0]       r_idx, n_idx;
    logic [CNT_W-1:0] r_ok_cnt, n_ok_cnt;
    logic [CNT_W-1:0] r_bad_cnt, n_bad_cnt;
    logic [CNT_W-1:0] r_ovf_cnt, n_ovf_cnt;

    logic                r_ovalid;
    t_status             r_ostatus;
    logic [7:0]          r_osrc, r_odst, r_omid, r_opbyte;
    logic [PLEN_W-1:0]   r_oplen;
    logic [PIDX_W-1:0]   r_opidx;
    logic                r_olast;

    logic                emit;
    t_status             e_status;
    logic [7:0]          e_src, e_dst, e_mid, e_pbyte;
    logic [PLEN_W-1:0]   e_plen;
    logic [PIDX_W-1:0]   e_pidx;
    logic                e_last;

    logic          slot;
    logic [OW-1:0] roff;
    logic          we;
    logic [PW-1:0] waddr;
    logic [PW-1:0] raddr;
    logic [7:0]    rdata;
    logic [9:0]    fill_ext;
    logic [9:0]    decl_now;
    logic [9:0]    total_now;
    logic [9:0]    total_reg;
    logic [9:0]    off_wide;
    logic [7:0]    plen_reg;
    logic [PW-1:0] head_p1;
    logic [PW-1:0] head_pt;
    logic [FW-1:0] fill_mt;

    assign slot      = !r_ovalid || !i_out_stall;
    assign fill_ext  = 10'(r_fill);
    assign decl_now  = {2'b00, rdata};
    assign total_now = decl_now + FRAME_EXTRA;
    assign total_reg = {2'b00, r_decl} + FRAME_EXTRA;
    assign plen_reg  = r_decl - 8'(LEN_BIAS);
    assign head_p1   = wrap_add(r_head, OW'(1));
    assign head_pt   = wrap_add(r_head, total_reg[OW-1:0]);
    assign fill_mt   = r_fill - total_reg[FW-1:0];
    assign waddr     = wrap_add(r_head, OW'(r_fill));
    assign raddr     = wrap_add(r_head, roff);

    sldf_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_fill    = r_fill;
        n_byte    = r_byte;
        n_b0      = r_b0;
        n_decl    = r_decl;
        n_src     = r_src;
        n_dst     = r_dst;
        n_mid     = r_mid;
        n_idx     = r_idx;
        n_ok_cnt  = r_ok_cnt;
        n_bad_cnt = r_bad_cnt;
        n_ovf_cnt = r_ovf_cnt;
        roff      = '0;
        we        = 1'b0;
        off_wide  = '0;
        emit      = 1'b0;
        e_status  = ST_NONE;
        e_src     = '0;
        e_dst     = '0;
        e_mid     = '0;
        e_plen    = '0;
        e_pbyte   = '0;
        e_pidx    = '0;
        e_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_rx_byte;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (r_fill >= FW'(WINDOW_DEPTH)) begin
                    if (slot) begin
                        emit      = 1'b1;
                        e_status  = ST_OVERFLOW;
                        n_fill    = '0;
                        n_ovf_cnt = r_ovf_cnt + 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    we      = 1'b1;
                    n_fill  = r_fill + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                roff = OW'(0);
                if (fill_ext < 10'(SYNC_BYTES)) begin
                    if (slot) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_A;
                end
            end
            S_A: begin
                roff    = OW'(1);
                n_b0    = rdata;
                n_state = S_B;
            end
            S_B: begin
                roff = OW'(1);
                if (r_b0 != r_start_first || rdata != r_start_second) begin
                    n_head  = head_p1;
                    n_fill  = r_fill - 1'b1;
                    n_state = S_SCAN;
                end else if (fill_ext < 10'(SYNC_BYTES + 1)) begin
                    if (slot) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    roff    = OW'(2);
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                roff = OW'(2);
                if (decl_now < DECL_MIN || decl_now > DECL_MAX) begin
                    if (slot) begin
                        emit      = 1'b1;
                        e_status  = ST_BAD;
                        n_head    = head_p1;
                        n_fill    = r_fill - 1'b1;
                        n_bad_cnt = r_bad_cnt + 1'b1;
                        n_state   = S_IDLE;
                    end
                end else if (fill_ext < total_now) begin
                    if (slot) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    off_wide = total_now - 10'(SYNC_BYTES);
                    roff     = off_wide[OW-1:0];
                    n_decl   = rdata;
                    n_state  = S_E0;
                end
            end
            S_E0: begin
                off_wide = total_reg - 10'(1);
                roff     = off_wide[OW-1:0];
                n_b0     = rdata;
                n_state  = S_E1;
            end
            S_E1: begin
                off_wide = total_reg - 10'(1);
                roff     = off_wide[OW-1:0];
                if (r_b0 != r_end_first || rdata != r_end_second) begin
                    if (slot) begin
                        emit      = 1'b1;
                        e_status  = ST_BAD;
                        n_head    = head_p1;
                        n_fill    = r_fill - 1'b1;
                        n_bad_cnt = r_bad_cnt + 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    roff    = OW'(SYNC_BYTES + 1);
                    n_state = S_H0;
                end
            end
            S_H0: begin
                roff    = OW'(SYNC_BYTES + 2);
                n_src   = rdata;
                n_state = S_H1;
            end
            S_H1: begin
                roff    = OW'(SYNC_BYTES + 3);
                n_dst   = rdata;
                n_state = S_H2;
            end
            S_H2: begin
                roff  = OW'(SYNC_BYTES + 3);
                n_mid = rdata;
                n_idx = '0;
                if (r_decl == 8'(LEN_BIAS)) begin
                    if (slot) begin
                        emit     = 1'b1;
                        e_status = ST_FRAME;
                        e_src    = r_src;
                        e_dst    = r_dst;
                        e_mid    = rdata;
                        n_ok_cnt = r_ok_cnt + 1'b1;
                        n_head   = head_pt;
                        n_fill   = fill_mt;
                        n_state  = S_IDLE;
                    end
                end else begin
                    roff    = OW'(SYNC_BYTES + 4);
                    n_state = S_PAY;
                end
            end
            S_PAY: begin
                off_wide = 10'(SYNC_BYTES + 4) + {2'b00, r_idx};
                if (slot) begin
                    off_wide = off_wide + 10'(1);
                    emit     = 1'b1;
                    e_status = ST_FRAME;
                    e_src    = r_src;
                    e_dst    = r_dst;
                    e_mid    = r_mid;
                    e_plen   = plen_reg[PLEN_W-1:0];
                    e_pbyte  = rdata;
                    e_pidx   = r_idx[PIDX_W-1:0];
                    e_last   = (r_idx + 1'b1 == plen_reg);
                    if (r_idx == '0) begin
                        n_ok_cnt = r_ok_cnt + 1'b1;
                    end
                    if (e_last) begin
                        n_head  = head_pt;
                        n_fill  = fill_mt;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                roff = off_wide[OW-1:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_fill    <= '0;
            r_ok_cnt  <= '0;
            r_bad_cnt <= '0;
            r_ovf_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_ok_cnt  <= n_ok_cnt;
            r_bad_cnt <= n_bad_cnt;
            r_ovf_cnt <= n_ovf_cnt;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_b0   <= n_b0;
        r_decl <= n_decl;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_mid  <= n_mid;
        r_idx  <= n_idx;
        if (emit) begin
            r_ostatus <= e_status;
            r_osrc    <= e_src;
            r_odst    <= e_dst;
            r_omid    <= e_mid;
            r_oplen   <= e_plen;
            r_opbyte  <= e_pbyte;
            r_opidx   <= e_pidx;
            r_olast   <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_first  <= START_FIRST_RST;
            r_start_second <= START_SECOND_RST;
            r_end_first    <= END_FIRST_RST;
            r_end_second   <= END_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_FIRST:  r_start_first  <= i_cfg_wdata;
                CFG_START_SECOND: r_start_second <= i_cfg_wdata;
                CFG_END_FIRST:    r_end_first    <= i_cfg_wdata;
                CFG_END_SECOND:   r_end_second   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_ovalid;
    assign o_status              = r_ostatus;
    assign o_source_id           = r_osrc;
    assign o_dest_id             = r_odst;
    assign o_message_id          = r_omid;
    assign o_payload_len         = r_oplen;
    assign o_payload_byte        = r_opbyte;
    assign o_payload_index       = r_opidx;
    assign o_last                = r_olast;
    assign o_frames_ok_total     = r_ok_cnt;
    assign o_format_errors_total = r_bad_cnt;
    assign o_overflows_total     = r_ovf_cnt;

    `SLDF_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(WINDOW_DEPTH))
    `SLDF_ASSERT_ALWAYS(a_head_bound, i_clk, i_rst_n, r_head <= PW'(WINDOW_DEPTH - 1))
    `SLDF_ASSERT_ALWAYS(a_pay_decl, i_clk, i_rst_n, (r_state != S_PAY) || (r_decl > 8'(LEN_BIAS)))
    `SLDF_ASSERT_NEXT(a_accept_write, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_WR)
    `SLDF_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, emit, o_out_valid)

endmodule

// ===== dv/sync_length_frame_deframer_core_checker.sv =====
// Checker for the frame deframer core: models the deframer on every accepted input beat
// and compares each accepted result beat, field by field, with the oldest predicted one.
// Depends on sldf_pkg.
module sync_length_frame_deframer_core_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [7:0]                  i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  sldf_pkg::t_status           i_status,
    input  logic [7:0]                  i_source_id,
    input  logic [7:0]                  i_dest_id,
    input  logic [7:0]                  i_message_id,
    input  logic [sldf_pkg::PLEN_W-1:0] i_payload_len,
    input  logic [7:0]                  i_payload_byte,
    input  logic [sldf_pkg::PIDX_W-1:0] i_payload_index,
    input  logic                        i_last,
    input  logic [sldf_pkg::CNT_W-1:0]  i_frames_ok_total,
    input  logic [sldf_pkg::CNT_W-1:0]  i_format_errors_total,
    input  logic [sldf_pkg::CNT_W-1:0]  i_overflows_total,
    output int                          o_fail_count,
    output int                          o_pending
);
    import sldf_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [7:0]         source_id;
        logic [7:0]         dest_id;
        logic [7:0]         message_id;
        logic [PLEN_W-1:0]  payload_len;
        logic [7:0]         payload_byte;
        logic [PIDX_W-1:0]  payload_index;
        logic               last;
        logic [CNT_W-1:0]   good_count;
        logic [CNT_W-1:0]   error_count;
        logic [CNT_W-1:0]   overflows;
    } t_decoded;

    t_decoded         decoded_q [$];
    logic [7:0]       rx_window [WINDOW_DEPTH_DEF];
    int unsigned      rx_fill;
    logic [CNT_W-1:0] good_count;
    logic [CNT_W-1:0] error_count;
    logic [CNT_W-1:0] overflows;
    logic [7:0]       sof_first;
    logic [7:0]       sof_second;
    logic [7:0]       eof_first;
    logic [7:0]       eof_second;

    function automatic t_decoded make_decoded(input t_status st, input logic [7:0] src,
                                              input logic [7:0] dst, input logic [7:0] mid,
                                              input int unsigned plen, input logic [7:0] pbyte,
                                              input int unsigned pidx, input logic last);
        t_decoded d;
        d.status        = st;
        d.source_id     = src;
        d.dest_id       = dst;
        d.message_id    = mid;
        d.payload_len   = PLEN_W'(plen);
        d.payload_byte  = pbyte;
        d.payload_index = PIDX_W'(pidx);
        d.last          = last;
        d.good_count    = good_count;
        d.error_count   = error_count;
        d.overflows     = overflows;
        return d;
    endfunction

    function automatic void drop_front(input int unsigned n);
        if (n >= rx_fill) begin
            rx_fill = 0;
        end else begin
            for (int unsigned k = 0; k < rx_fill - n; k++) begin
                rx_window[k] = rx_window[k + n];
            end
            rx_fill -= n;
        end
    endfunction

    task automatic deframe_byte(input logic [7:0] rx);
        int unsigned decl;
        int unsigned total;
        int unsigned plen;
        bit          done;
        done = 1'b0;
        if (rx_fill >= WINDOW_DEPTH_DEF) begin
            rx_fill = 0;
            overflows++;
            decoded_q.push_back(make_decoded(ST_OVERFLOW, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
        end
        rx_window[rx_fill] = rx;
        rx_fill++;
        while (!done) begin
            if (rx_fill < SYNC_BYTES) begin
                decoded_q.push_back(make_decoded(ST_NONE, 0, 0, 0, 0, 0, 0, 1'b1));
                done = 1'b1;
            end else if (rx_window[0] != sof_first || rx_window[1] != sof_second) begin
                drop_front(1);
            end else if (rx_fill < SYNC_BYTES + 1) begin
                decoded_q.push_back(make_decoded(ST_NONE, 0, 0, 0, 0, 0, 0, 1'b1));
                done = 1'b1;
            end else begin
                decl  = rx_window[2];
                total = SYNC_BYTES + 1 + decl + SYNC_BYTES;
                done  = 1'b1;
                if (decl < LEN_BIAS || decl > LEN_BIAS + MAX_PAYLOAD_DEF) begin
                    drop_front(1);
                    error_count++;
                    decoded_q.push_back(make_decoded(ST_BAD, 0, 0, 0, 0, 0, 0, 1'b1));
                end else if (rx_fill < total) begin
                    decoded_q.push_back(make_decoded(ST_NONE, 0, 0, 0, 0, 0, 0, 1'b1));
                end else if (rx_window[total - 2] != eof_first ||
                             rx_window[total - 1] != eof_second) begin
                    drop_front(1);
                    error_count++;
                    decoded_q.push_back(make_decoded(ST_BAD, 0, 0, 0, 0, 0, 0, 1'b1));
                end else begin
                    plen = decl - LEN_BIAS;
                    good_count++;
                    if (plen == 0) begin
                        decoded_q.push_back(make_decoded(ST_FRAME, rx_window[3], rx_window[4],
                                                         rx_window[5], 0, 0, 0, 1'b1));
                    end else begin
                        for (int unsigned i = 0; i < plen; i++) begin
                            decoded_q.push_back(make_decoded(ST_FRAME, rx_window[3],
                                                             rx_window[4], rx_window[5], plen,
                                                             rx_window[6 + i], i,
                                                             i + 1 == plen));
                        end
                    end
                    drop_front(total);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            rx_fill     = 0;
            good_count  = '0;
            error_count = '0;
            overflows   = '0;
            sof_first   = START_FIRST_RST;
            sof_second  = START_SECOND_RST;
            eof_first   = END_FIRST_RST;
            eof_second  = END_SECOND_RST;
            decoded_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_FIRST: sof_first = i_cfg_wdata;
                    CFG_START_SECOND: sof_second = i_cfg_wdata;
                    CFG_END_FIRST: eof_first = i_cfg_wdata;
                    CFG_END_SECOND: eof_second = i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_rx_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("result beat with no expected result, status %0d", i_status);
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("source_id", want.source_id, i_source_id);
                    check_field("dest_id", want.dest_id, i_dest_id);
                    check_field("message_id", want.message_id, i_message_id);
                    check_field("payload_len", want.payload_len, i_payload_len);
                    check_field("payload_byte", want.payload_byte, i_payload_byte);
                    check_field("payload_index", want.payload_index, i_payload_index);
                    check_field("last", want.last, i_last);
                    check_field("frames_ok_total", want.good_count, i_frames_ok_total);
                    check_field("format_errors_total", want.error_count,
                                i_format_errors_total);
                    check_field("overflows_total", want.overflows, i_overflows_total);
                end
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

// ===== dv/sync_length_frame_deframer_core_tb.sv =====
// Testbench top for the frame deframer core: clock, reset, sync byte programming and
// byte stream stimulus with random idling; the checker beside the block does the scoring.
// Depends on sldf_pkg, the core and sync_length_frame_deframer_core_checker.
module sync_length_frame_deframer_core_tb;
    import sldf_pkg::*;

    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         DRAIN_CYCLES = 300;
    localparam logic [7:0] LONGEST_LEN = 8'(LEN_BIAS + MAX_PAYLOAD_DEF);

    typedef enum {FLAW_NONE, FLAW_LENGTH, FLAW_END, FLAW_CUT} t_flaw;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = CFG_START_FIRST;
    logic [7:0]           cfg_wdata = 8'h00;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_status              status;
    logic [7:0]           source_id;
    logic [7:0]           dest_id;
    logic [7:0]           message_id;
    logic [PLEN_W-1:0]    payload_len;
    logic [7:0]           payload_byte;
    logic [PIDX_W-1:0]    payload_index;
    logic                 last;
    logic [CNT_W-1:0]     frames_ok_total;
    logic [CNT_W-1:0]     format_errors_total;
    logic [CNT_W-1:0]     overflows_total;
    int                   fail_count;
    int                   pending;
    int                   cycles = 0;
    int                   bytes_sent = 0;
    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   phase_gap_pct = 0;
    int                   phase_stall_pct = 0;
    logic [7:0]           sof_first = START_FIRST_RST;
    logic [7:0]           sof_second = START_SECOND_RST;
    logic [7:0]           eof_first = END_FIRST_RST;
    logic [7:0]           eof_second = END_SECOND_RST;

    sync_length_frame_deframer_core dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_wdata           (cfg_wdata),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_rx_byte             (rx_byte),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_status              (status),
        .o_source_id           (source_id),
        .o_dest_id             (dest_id),
        .o_message_id          (message_id),
        .o_payload_len         (payload_len),
        .o_payload_byte        (payload_byte),
        .o_payload_index       (payload_index),
        .o_last                (last),
        .o_frames_ok_total     (frames_ok_total),
        .o_format_errors_total (format_errors_total),
        .o_overflows_total     (overflows_total)
    );

    sync_length_frame_deframer_core_checker u_chk (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_wdata           (cfg_wdata),
        .i_in_valid            (in_valid),
        .i_in_stall            (in_stall),
        .i_rx_byte             (rx_byte),
        .i_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .i_status              (status),
        .i_source_id           (source_id),
        .i_dest_id             (dest_id),
        .i_message_id          (message_id),
        .i_payload_len         (payload_len),
        .i_payload_byte        (payload_byte),
        .i_payload_index       (payload_index),
        .i_last                (last),
        .i_frames_ok_total     (frames_ok_total),
        .i_format_errors_total (format_errors_total),
        .i_overflows_total     (overflows_total),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    always #10 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic set_idling(input int gap, input int stall);
        phase_gap_pct   = gap;
        phase_stall_pct = stall;
        gap_pct         = gap;
        stall_pct       = stall;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    task automatic program_sync(input logic [7:0] s1, input logic [7:0] s2,
                                input logic [7:0] e1, input logic [7:0] e2);
        write_reg(CFG_START_FIRST, s1);
        write_reg(CFG_START_SECOND, s2);
        write_reg(CFG_END_FIRST, e1);
        write_reg(CFG_END_SECOND, e2);
        cfg_we     <= 1'b0;
        sof_first  = s1;
        sof_second = s2;
        eof_first  = e1;
        eof_second = e2;
    endtask

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_list(input logic [7:0] seq [$]);
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    // hold valid low until every predicted result beat has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic send_frame(input int plen, input t_flaw flaw);
        logic [7:0] seq [$];
        int         keep;
        int         pick;
        seq.push_back(sof_first);
        seq.push_back(sof_second);
        if (flaw == FLAW_LENGTH) begin
            if ($urandom_range(1) == 0) seq.push_back(8'($urandom_range(LEN_BIAS - 1)));
            else seq.push_back(8'($urandom_range(255, LONGEST_LEN + 1)));
        end else begin
            seq.push_back(8'(plen + LEN_BIAS));
        end
        repeat (3 + plen) seq.push_back(8'($urandom));
        if (flaw == FLAW_END) begin
            pick = $urandom_range(2);
            seq.push_back(pick == 1 ? eof_first : eof_first ^ 8'($urandom_range(255, 1)));
            seq.push_back(pick == 0 ? eof_second : eof_second ^ 8'($urandom_range(255, 1)));
        end else begin
            seq.push_back(eof_first);
            seq.push_back(eof_second);
        end
        if (flaw == FLAW_CUT) begin
            keep = $urandom_range(seq.size() - 1, 3);
            while (seq.size() > keep) void'(seq.pop_back());
        end
        send_list(seq);
    endtask

    function automatic int pick_plen();
        int r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(3);
        if (r < 90) return $urandom_range(12, 4);
        return $urandom_range(MAX_PAYLOAD_DEF, 13);
    endfunction

    task automatic run_traffic(input int budget);
        int    first;
        int    frames;
        int    r;
        t_flaw flaw;
        first  = bytes_sent;
        frames = 0;
        while (bytes_sent - first < budget) begin
            if ($urandom_range(99) < 20) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = phase_gap_pct;
                stall_pct = phase_stall_pct;
            end
            r = $urandom_range(99);
            if (r < 70) flaw = FLAW_NONE;
            else if (r < 80) flaw = FLAW_LENGTH;
            else if (r < 90) flaw = FLAW_END;
            else flaw = FLAW_CUT;
            send_frame(pick_plen(), flaw);
            if ($urandom_range(99) < 30) repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            frames++;
            if (frames == 3) wait_drained();
        end
        gap_pct   = phase_gap_pct;
        stall_pct = phase_stall_pct;
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(32, 52);
        send_list({START_FIRST_RST, START_SECOND_RST, 8'(LEN_BIAS), 8'h00, 8'hFF, 8'h00,
                   END_FIRST_RST, END_SECOND_RST});
        send_list({START_FIRST_RST, START_SECOND_RST, 8'(LEN_BIAS - 1)});
        send_list({START_FIRST_RST, START_SECOND_RST, 8'(LONGEST_LEN + 1)});
        send_list({START_FIRST_RST, START_SECOND_RST, 8'(LEN_BIAS + 1), 8'h7E, 8'h81, 8'h3C,
                   8'hFF, END_FIRST_RST, END_SECOND_RST});
        wait_drained();

        program_sync(8'h00, 8'hFF, 8'hFF, 8'h00);
        run_traffic(15);
        wait_drained();

        set_idling(52, 32);
        program_sync(8'hFF, 8'h00, 8'h00, 8'hFF);
        run_traffic(15);
        wait_drained();

        set_idling(0, 0);
        program_sync(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_frame(MAX_PAYLOAD_DEF, FLAW_NONE);
        run_traffic(15);
        wait_drained();

        // sync bytes equal to the longest length: the window sticks one byte short and
        // every later byte is a bad frame
        program_sync(LONGEST_LEN, LONGEST_LEN, ~LONGEST_LEN, 8'($urandom));
        repeat (45) send_byte(LONGEST_LEN);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sync_length_frame_deframer_core.f =====
+incdir+rtl
rtl/sldf_pkg.sv
rtl/sldf_ram.sv
rtl/sync_length_frame_deframer_core.sv
dv/sync_length_frame_deframer_core_checker.sv
dv/sync_length_frame_deframer_core_tb.sv
